>>> sv/fct_pkg.sv
// Shared constants for the Fenwick count tree block.
// Used by the channel interfaces and by every module of the block.
package fct_pkg;

    localparam int MAX_SIZE_DEF    = 1024;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int INDEX_W  = 10;
    localparam int SIZE_W   = 11;
    localparam int RESULT_W = 32;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_ACTIVE_SIZE = 1'b0;

    localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = 11'd1024;

endpackage

>>> sv/fct_in_if.sv
// Input item channel of the Fenwick count tree: valid/ready plus command fields.
// Depends on fct_pkg for the field widths.
interface fct_in_if
    import fct_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] last_index;

    modport source (output valid, cmd, first_index, last_index, input ready);
    modport sink   (input valid, cmd, first_index, last_index, output ready);
endinterface

>>> sv/fct_out_if.sv
// Result item channel of the Fenwick count tree: valid/ready plus count and overflow.
// Depends on fct_pkg for the field widths.
interface fct_out_if
    import fct_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] count;
    logic                overflow;

    modport source (output valid, count, overflow, input ready);
    modport sink   (input valid, count, overflow, output ready);
endinterface

>>> sv/fct_regs.sv
// APB-style configuration register file holding active_size.
// Depends on fct_pkg for widths, the register index and the reset value.
module fct_regs
    import fct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [SIZE_W-1:0]  active_size
);

    logic [SIZE_W-1:0] active_size_reg;
    logic [SIZE_W-1:0] active_size_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_SIZE);

    always_comb
    begin
        active_size_next = active_size_reg;
        if (wr_en)
        begin
            active_size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= ACTIVE_SIZE_RESET;
        end
        else
        begin
            active_size_reg <= active_size_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ACTIVE_SIZE)
        begin
            prdata = {{(PDATA_W-SIZE_W){1'b0}}, active_size_reg};
        end
    end

    assign active_size = active_size_reg;

endmodule

>>> sv/fct_node_mem.sv
// Node count memory: one write port, one read port, registered read data.
// Depends on fct_pkg for its parameter defaults; sized by its parameters.
module fct_node_mem
    import fct_pkg::*;
#(
    parameter int DEPTH = MAX_SIZE_DEF,
    parameter int DW    = COUNT_WIDTH_DEF,
    parameter int AW    = $clog2(MAX_SIZE_DEF)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fct_walker.sv
// Tree walk sequencer: clears the node memory, runs insert and prefix walks,
// and holds the total count and the result register. Depends on fct_pkg.
module fct_walker
    import fct_pkg::*;
#(
    parameter int MAX_SIZE    = MAX_SIZE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int AW          = $clog2(MAX_SIZE_DEF)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SIZE_W-1:0]      active_size,
    fct_in_if.sink                 req,
    fct_out_if.source              rsp,
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output logic [COUNT_WIDTH-1:0] mem_wdata,
    output logic                   mem_re,
    output logic [AW-1:0]          mem_raddr,
    input  logic [COUNT_WIDTH-1:0] mem_rdata
);

    localparam int NW   = $clog2(MAX_SIZE + 1);
    localparam int CMPW = ((NW > SIZE_W) ? NW : SIZE_W) + 1;
    localparam int CW   = COUNT_WIDTH;
    localparam logic [CMPW-1:0] MAX_C   = CMPW'(MAX_SIZE);
    localparam logic [NW:0]     MAX_UP  = (NW+1)'(MAX_SIZE);
    localparam logic [AW-1:0]   LAST_AD = AW'(MAX_SIZE - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INSERT,
        ST_QUERY,
        ST_DONE
    } state_t;

    state_t          state_reg,     state_next;
    logic [AW-1:0]   clr_addr_reg,  clr_addr_next;
    logic [NW-1:0]   node_reg,      node_next;
    logic [NW-1:0]   lo_node_reg,   lo_node_next;
    logic            pend_reg,      pend_next;
    logic [AW-1:0]   pend_addr_reg, pend_addr_next;
    logic            phase_reg,     phase_next;
    logic [CW-1:0]   acc_reg,       acc_next;
    logic [CW-1:0]   first_reg,     first_next;
    logic [CW-1:0]   total_reg,     total_next;
    logic [CW-1:0]   res_count_reg, res_count_next;
    logic            res_ovf_reg,   res_ovf_next;
    logic            out_valid_reg, out_valid_next;
    logic [CW-1:0]   out_count_reg, out_count_next;
    logic            out_ovf_reg,   out_ovf_next;

    logic [CMPW-1:0] size_c;
    logic [CMPW-1:0] last_c;
    logic [CMPW-1:0] lo_c;
    logic [CMPW-1:0] hi_c;
    logic [CMPW-1:0] q_lo;
    logic [CMPW-1:0] q_hi;
    logic [CMPW-1:0] q_hi_p1;
    logic [CMPW-1:0] ins_p1;
    logic            ins_ok;
    logic            total_full;
    logic [NW-1:0]   node_low;
    logic [NW-1:0]   node_m1;
    logic [NW:0]     up_sum;
    logic [NW-1:0]   up_next;
    logic [NW-1:0]   down_next;
    logic [AW-1:0]   node_addr;
    logic [CW-1:0]   acc_sum;
    logic [CW+RESULT_W-1:0] count_ext;

    // Effective size: zero acts as one, anything above the tree acts as the tree size.
    always_comb
    begin
        if (active_size == '0)
        begin
            size_c = CMPW'(1);
        end
        else if (CMPW'(active_size) > MAX_C)
        begin
            size_c = MAX_C;
        end
        else
        begin
            size_c = CMPW'(active_size);
        end
    end

    assign last_c     = size_c - CMPW'(1);
    assign lo_c       = CMPW'(req.first_index);
    assign hi_c       = CMPW'(req.last_index);
    assign q_lo       = (lo_c > last_c) ? last_c : lo_c;
    assign q_hi       = (hi_c > last_c) ? last_c : hi_c;
    assign q_hi_p1    = q_hi + CMPW'(1);
    assign ins_p1     = lo_c + CMPW'(1);
    assign ins_ok     = lo_c < size_c;
    assign total_full = total_reg == {CW{1'b1}};

    assign node_low  = node_reg & (~node_reg + NW'(1));
    assign node_m1   = node_reg - NW'(1);
    assign node_addr = node_m1[AW-1:0];
    assign up_sum    = {1'b0, node_reg} + {1'b0, node_low};
    assign up_next   = (up_sum > MAX_UP) ? '0 : up_sum[NW-1:0];
    assign down_next = node_reg - node_low;
    assign acc_sum   = pend_reg ? (acc_reg + mem_rdata) : acc_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        node_next      = node_reg;
        lo_node_next   = lo_node_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        first_next     = first_reg;
        total_next     = total_reg;
        res_count_next = res_count_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;

        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = mem_rdata + CW'(1);
        mem_re    = 1'b0;
        mem_raddr = node_addr;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == LAST_AD)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_count_next = '0;
                    res_ovf_next   = 1'b0;
                    pend_next      = 1'b0;
                    if (req.cmd == CMD_INSERT)
                    begin
                        if (!ins_ok)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (total_full)
                        begin
                            res_ovf_next = 1'b1;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            total_next = total_reg + CW'(1);
                            node_next  = ins_p1[NW-1:0];
                            state_next = ST_INSERT;
                        end
                    end
                    else
                    begin
                        if (q_lo > q_hi)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            node_next    = q_hi_p1[NW-1:0];
                            lo_node_next = q_lo[NW-1:0];
                            acc_next     = '0;
                            phase_next   = 1'b0;
                            state_next   = ST_QUERY;
                        end
                    end
                end
            end

            ST_INSERT:
            begin
                // Write back the node read last cycle while reading the next one up.
                mem_we = pend_reg;
                if (node_reg != '0)
                begin
                    mem_re         = 1'b1;
                    pend_addr_next = node_addr;
                    node_next      = up_next;
                    pend_next      = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_QUERY:
            begin
                acc_next = acc_sum;
                if (node_reg != '0)
                begin
                    mem_re    = 1'b1;
                    node_next = down_next;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (!phase_reg)
                        begin
                            // Upper prefix done; start the lower prefix walk.
                            first_next = acc_reg;
                            acc_next   = '0;
                            node_next  = lo_node_reg;
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            res_count_next = first_reg - acc_reg;
                            state_next     = ST_DONE;
                        end
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = res_count_reg;
                    out_ovf_next   = res_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            node_reg      <= '0;
            lo_node_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            phase_reg     <= 1'b0;
            acc_reg       <= '0;
            first_reg     <= '0;
            total_reg     <= '0;
            res_count_reg <= '0;
            res_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            node_reg      <= node_next;
            lo_node_reg   <= lo_node_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            first_reg     <= first_next;
            total_reg     <= total_next;
            res_count_reg <= res_count_next;
            res_ovf_reg   <= res_ovf_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    assign count_ext    = {{RESULT_W{1'b0}}, out_count_reg};
    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.count    = count_ext[RESULT_W-1:0];
    assign rsp.overflow = out_ovf_reg;

    // Prefix walks never modify the tree.
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QUERY) |-> !mem_we)
        else $error("node memory written during a query walk");

    // A write-back never targets the node being read in the same cycle.
    a_rmw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same node in one cycle");

    // The total only ever steps up by one.
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != $past(total_reg)) |-> (total_reg == $past(total_reg) + CW'(1)))
        else $error("total count changed by other than one");

    // A dropped insert reports a zero count.
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ovf_reg) |-> (out_count_reg == '0))
        else $error("overflow result with nonzero count");

    // The walk index stays inside the tree.
    a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
        (NW+1)'(node_reg) <= MAX_UP)
        else $error("node index beyond tree size");

endmodule

>>> sv/fenwick_count_tree.sv
// Fenwick count tree: one item at a time, insert walks upward, queries take two prefix walks.
// Insert: the walk visits at most log2(MAX_SIZE)+1 nodes.
// Query: one node memory read per cycle sets the pace of each walk.
// Dropped inserts and empty ranges skip the walks; a new item is taken once its result is posted.
// After reset the node memory is cleared one entry a cycle, all MAX_SIZE entries, item input stalled.
// Depends on fct_pkg, fct_in_if, fct_out_if, fct_regs, fct_node_mem and fct_walker.
module fenwick_count_tree
    import fct_pkg::*;
#(
    parameter int MAX_SIZE    = MAX_SIZE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    fct_in_if.sink             req,
    fct_out_if.source          rsp
);

    localparam int AW = $clog2(MAX_SIZE);

    logic [SIZE_W-1:0]      active_size;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [COUNT_WIDTH-1:0] mem_rdata;

    fct_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .active_size (active_size)
    );

    fct_walker #(
        .MAX_SIZE    (MAX_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH),
        .AW          (AW)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .active_size (active_size),
        .req         (req),
        .rsp         (rsp),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    fct_node_mem #(
        .DEPTH (MAX_SIZE),
        .DW    (COUNT_WIDTH),
        .AW    (AW)
    ) u_node_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
